>>> design/credential_table_engine_macros.svh
// Assertion macros shared by the credential table engine RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef CREDENTIAL_TABLE_ENGINE_MACROS_SVH
`define CREDENTIAL_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("credential table engine check failed");

// Next-cycle implication, disabled during reset.
`define CTE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("credential table engine check failed");

`endif

>>> design/cte_pkg.sv
// Types and constants for the credential table engine.
// No dependencies; imported by cte_match, credential_table_engine and tb_top.
package cte_pkg;

   localparam int CMD_W = 2;
   localparam int ID_W  = 8;
   localparam int PW_W  = 32;
   localparam int OUT_W = 2;
   localparam int REQ_W = 48;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_VERIFY = 2'd2;

   localparam logic [OUT_W-1:0] OUT_FAIL = 2'd0;
   localparam logic [OUT_W-1:0] OUT_OK   = 2'd1;
   localparam logic [OUT_W-1:0] OUT_USER = 2'd2;

   localparam logic [PW_W-1:0] ADMIN_RESET = 32'h3132_3334;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [PW_W-1:0] pw;
   } entry_type;

   typedef enum logic [1:0] {
      MATCH_ID    = 2'd0,
      MATCH_PW    = 2'd1,
      MATCH_ADMIN = 2'd2
   } match_mode_type;

   typedef struct packed {
      match_mode_type  mode;
      logic [ID_W-1:0] id;
      logic [PW_W-1:0] pw;
   } match_req_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ADMIN = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

endpackage

>>> design/credential_table_engine.sv
// Credential table engine: packed user table with add, delete and verify.
// Depends on cte_pkg, cte_match and credential_table_engine_macros.svh.
//
// One command is taken at a time; req_tready is high only while the engine is
// idle. Add, an unused command and a delete on an empty table go straight to
// the done state, and a verify first checks the admin password. Delete and a
// verify that misses the admin password walk the table one entry per cycle
// through the single read port of the entry memory. A delete reads every
// entry, whether or not the ID is found; a verify stops early when a user
// entry matches. Delete moves later entries down in the same walk, reading
// one entry and writing the one below it each cycle. The result sits in an
// output register, so the engine returns to idle once it is taken or the
// register is free; a stalled result holds the engine in its done state.
// The admin password register is written through the csr_ channel, which is
// always ready.
module credential_table_engine
   import cte_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1),
   localparam int RSP_W = ((OUT_W + CNT_W + 7) / 8) * 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // command[1:0], user_id[9:2], password[41:10]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // outcome[1:0], entries_used[CNT_W+1:2]
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [PW_W-1:0]  csr_data
);

`include "credential_table_engine_macros.svh"

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   state_type        state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [PW_W-1:0]  pw_ff, pw_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] q_idx_ff;
   logic             q_valid_ff;
   entry_type        q_ff;
   logic [OUT_W-1:0] outcome_ff, outcome_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [PW_W-1:0]  admin_ff, admin_in;

   entry_type        mem [TABLE_ENTRIES];
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   entry_type        mem_wd;

   logic             req_xfer;
   logic             issue;
   logic             rsp_load;
   logic             hit;
   match_req_type    mreq;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign issue = ((state_ff == S_SCAN) || (state_ff == S_SHIFT)) && (rd_idx_ff < count_ff);

   always_comb begin
      mreq.id = id_ff;
      mreq.pw = pw_ff;
      if (state_ff == S_ADMIN) begin
         mreq.mode = MATCH_ADMIN;
      end else if (cmd_ff == CMD_DELETE) begin
         mreq.mode = MATCH_ID;
      end else begin
         mreq.mode = MATCH_PW;
      end
   end

   cte_match u_match (
      .req            (mreq),
      .entry          (q_ff),
      .admin_password (admin_ff),
      .hit            (hit)
   );

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      id_in      = id_ff;
      pw_in      = pw_ff;
      count_in   = count_ff;
      outcome_in = outcome_ff;
      rd_idx_in  = issue ? rd_idx_ff + CNT_W'(1) : rd_idx_ff;
      mem_we     = 1'b0;
      mem_wa     = q_idx_ff - IDX_W'(1);
      mem_wd     = q_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in    = req_tdata[1:0];
               id_in     = req_tdata[9:2];
               pw_in     = req_tdata[41:10];
               rd_idx_in = '0;
               state_in  = S_DONE;
               outcome_in = OUT_FAIL;
               case (req_tdata[1:0])
                  CMD_ADD: begin
                     if (count_ff < CNT_W'(TABLE_ENTRIES)) begin
                        mem_we     = 1'b1;
                        mem_wa     = count_ff[IDX_W-1:0];
                        mem_wd.id  = req_tdata[9:2];
                        mem_wd.pw  = req_tdata[41:10];
                        count_in   = count_ff + CNT_W'(1);
                        outcome_in = OUT_OK;
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_VERIFY: begin
                     state_in = S_ADMIN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ADMIN: begin
            if (hit) begin
               outcome_in = OUT_OK;
               state_in   = S_DONE;
            end else if (count_ff == '0) begin
               outcome_in = OUT_FAIL;
               state_in   = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (q_valid_ff && hit) begin
               if (cmd_ff == CMD_DELETE) begin
                  state_in = S_SHIFT;
               end else begin
                  outcome_in = OUT_USER;
                  state_in   = S_DONE;
               end
            end else if (!issue && !q_valid_ff) begin
               outcome_in = OUT_FAIL;
               state_in   = S_DONE;
            end
         end
         S_SHIFT: begin
            if (q_valid_ff) begin
               mem_we = 1'b1;
            end else if (!issue) begin
               count_in   = count_ff - CNT_W'(1);
               outcome_in = OUT_OK;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_data_in = rsp_load ? RSP_W'({count_ff, outcome_ff}) : rsp_data_ff;
      admin_in    = csr_valid ? csr_data : admin_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      q_ff <= mem[rd_idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         q_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         admin_ff     <= ADMIN_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         q_valid_ff   <= issue;
         rsp_valid_ff <= rsp_valid_in;
         admin_ff     <= admin_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      pw_ff       <= pw_in;
      rd_idx_ff   <= rd_idx_in;
      q_idx_ff    <= rd_idx_ff[IDX_W-1:0];
      outcome_ff  <= outcome_in;
      rsp_data_ff <= rsp_data_in;
   end

   `CTE_ASSERT_SAME(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_ENTRIES))
   `CTE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, state_ff != S_IDLE)
   `CTE_ASSERT_SAME(a_shift_below_count, clock, reset, state_ff == S_SHIFT && mem_we, CNT_W'(mem_wa) < count_ff)
   `CTE_ASSERT_NEXT(a_done_loads_rsp, clock, reset, rsp_load, rsp_valid_ff)

endmodule

>>> design/cte_match.sv
// Shared equality unit: one comparator fed by an operand select.
// Depends on cte_pkg.
module cte_match
   import cte_pkg::*;
(
   input  match_req_type   req,
   input  entry_type       entry,
   input  logic [PW_W-1:0] admin_password,
   output logic            hit
);

   logic [PW_W-1:0] lhs;
   logic [PW_W-1:0] rhs;

   always_comb begin
      case (req.mode)
         MATCH_ID: begin
            lhs = PW_W'(entry.id);
            rhs = PW_W'(req.id);
         end
         MATCH_PW: begin
            lhs = entry.pw;
            rhs = req.pw;
         end
         MATCH_ADMIN: begin
            lhs = admin_password;
            rhs = req.pw;
         end
         default: begin
            lhs = '0;
            rhs = '1;
         end
      endcase
   end

   assign hit = (lhs == rhs);

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for credential_table_engine: add, delete and verify commands.
// Depends on cte_pkg and the engine RTL; predicts untyped rows from a shadow table.
`timescale 1ns / 1ps

module tb_top;
   import cte_pkg::*;

   localparam int TABLE_ENTRIES  = 16;
   localparam int USED_W         = 5;
   localparam int RSP_W          = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 250;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [ID_W-1:0]   id;
      logic [PW_W-1:0]   pw;
      bit                typed;
      logic [OUT_W-1:0]  outcome;
      logic [USED_W-1:0] used;
   } stim_row_type;

   typedef struct {
      logic [OUT_W-1:0]  outcome;
      logic [USED_W-1:0] used;
   } verdict_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // command[1:0], user_id[9:2], password[41:10]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // outcome[1:0], entries_used[6:2]
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [PW_W-1:0]  csr_data = '0;

   logic [ID_W-1:0]  shadow_ids [TABLE_ENTRIES];
   logic [PW_W-1:0]  shadow_pws [TABLE_ENTRIES];
   int               shadow_used = 0;
   logic [PW_W-1:0]  shadow_admin = ADMIN_RESET;

   verdict_type      pending_verdicts [$];
   stim_row_type     directed_rows [$];

   bit               row_typed = 1'b0;
   logic [OUT_W-1:0] row_outcome = '0;
   logic [USED_W-1:0] row_used = '0;

   int src_idle_pct = 0;
   int rcv_stall_pct = 0;
   int fail_count = 0;
   int quiet_cycles = 0;
   int n_cmds = 0, n_added = 0, n_full = 0, n_deleted = 0, n_missing = 0;
   int n_admin = 0, n_user = 0, n_invalid = 0, n_unused = 0, n_csr = 0, n_rsp = 0;

   credential_table_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void run_credential_cmd(input logic [CMD_W-1:0] cmd,
                                              input logic [ID_W-1:0] id,
                                              input logic [PW_W-1:0] pw,
                                              output logic [OUT_W-1:0] outcome);
      int i;
      int hit;
      outcome = OUT_FAIL;
      hit = -1;
      case (cmd)
         CMD_ADD: begin
            if (shadow_used < TABLE_ENTRIES) begin
               shadow_ids[shadow_used] = id;
               shadow_pws[shadow_used] = pw;
               shadow_used++;
               outcome = OUT_OK;
            end
         end
         CMD_DELETE: begin
            for (i = 0; i < shadow_used; i++)
               if (hit < 0 && shadow_ids[i] == id) hit = i;
            if (hit >= 0) begin
               for (i = hit; i + 1 < shadow_used; i++) begin
                  shadow_ids[i] = shadow_ids[i + 1];
                  shadow_pws[i] = shadow_pws[i + 1];
               end
               shadow_used--;
               outcome = OUT_OK;
            end
         end
         CMD_VERIFY: begin
            if (pw == shadow_admin) begin
               outcome = OUT_OK;
            end else begin
               for (i = 0; i < shadow_used; i++)
                  if (shadow_pws[i] == pw) outcome = OUT_USER;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic stim_row_type row(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                        input logic [PW_W-1:0] pw, input bit typed,
                                        input logic [OUT_W-1:0] outcome,
                                        input logic [USED_W-1:0] used);
      stim_row_type r;
      r.cmd = cmd;
      r.id = id;
      r.pw = pw;
      r.typed = typed;
      r.outcome = outcome;
      r.used = used;
      return r;
   endfunction

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rcv_stall_pct);
   end

   always @(posedge clock) begin
      verdict_type       want;
      verdict_type       got;
      logic [OUT_W-1:0]  predicted;
      logic [CMD_W-1:0]  cmd;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            got.outcome = rsp_tdata[1:0];
            got.used = rsp_tdata[6:2];
            if (pending_verdicts.size() == 0) begin
               fail_count++;
               $display("%0t: response with none pending, got outcome %0d used %0d",
                        $time, got.outcome, got.used);
            end else begin
               want = pending_verdicts.pop_front();
               if (got.outcome !== want.outcome) begin
                  fail_count++;
                  $display("%0t: outcome mismatch, expected %0d, got %0d",
                           $time, want.outcome, got.outcome);
               end
               if (got.used !== want.used) begin
                  fail_count++;
                  $display("%0t: entries_used mismatch, expected %0d, got %0d",
                           $time, want.used, got.used);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            cmd = req_tdata[1:0];
            run_credential_cmd(cmd, req_tdata[9:2], req_tdata[41:10], predicted);
            n_cmds++;
            case (cmd)
               CMD_ADD:    if (predicted == OUT_OK) n_added++; else n_full++;
               CMD_DELETE: if (predicted == OUT_OK) n_deleted++; else n_missing++;
               CMD_VERIFY: begin
                  if (predicted == OUT_OK) n_admin++;
                  else if (predicted == OUT_USER) n_user++;
                  else n_invalid++;
               end
               default:    n_unused++;
            endcase
            if (row_typed) begin
               want.outcome = row_outcome;
               want.used = row_used;
            end else begin
               want.outcome = predicted;
               want.used = shadow_used[USED_W-1:0];
            end
            pending_verdicts.push_back(want);
         end
         if (csr_valid && csr_ready) begin
            shadow_admin = csr_data;
            n_csr++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d responses pending",
                     $time, quiet_cycles, pending_verdicts.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_cmd(input stim_row_type r);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata = REQ_W'({$urandom, $urandom});
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {6'b0, r.pw, r.id, r.cmd};
      row_typed = r.typed;
      row_outcome = r.outcome;
      row_used = r.used;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_pending();
      req_tvalid = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
   endtask

   task automatic write_admin(input logic [PW_W-1:0] value);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic pick_random_cmd(input int add_pct, output stim_row_type r);
      int sel;
      sel = $urandom_range(99);
      r.typed = 1'b0;
      r.outcome = '0;
      r.used = '0;
      if (sel < 4) r.cmd = CMD_UNUSED;
      else if (sel < 4 + add_pct) r.cmd = CMD_ADD;
      else if (sel < 4 + add_pct + (96 - add_pct) / 2) r.cmd = CMD_DELETE;
      else r.cmd = CMD_VERIFY;

      if (r.cmd == CMD_DELETE && shadow_used > 0 && $urandom_range(3) != 0)
         r.id = shadow_ids[$urandom_range(shadow_used - 1)];
      else if ($urandom_range(1) == 0)
         r.id = ID_W'($urandom_range(7));
      else
         r.id = ID_W'($urandom_range(255));

      sel = $urandom_range(9);
      r.pw = $urandom;
      if (r.cmd == CMD_VERIFY) begin
         if (sel < 3) r.pw = shadow_admin;
         else if (sel < 7 && shadow_used > 0) r.pw = shadow_pws[$urandom_range(shadow_used - 1)];
         else if (sel == 7) r.pw = shadow_pws[$urandom_range(TABLE_ENTRIES - 1)];
      end else if (r.cmd == CMD_ADD) begin
         if (sel == 0) r.pw = shadow_admin;
         else if (sel == 1) r.pw = PW_W'($urandom_range(3));
      end
   endtask

   initial begin
      stim_row_type r;
      int           p;
      int           k;
      int           add_pct;

      foreach (shadow_ids[i]) begin
         shadow_ids[i] = '0;
         shadow_pws[i] = '0;
      end

      directed_rows.push_back(row(CMD_VERIFY, 8'h00, ADMIN_RESET,   1, OUT_OK,   5'd0));
      directed_rows.push_back(row(CMD_VERIFY, 8'hFF, 32'h0,         1, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_DELETE, 8'h00, 32'h0,         1, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_ADD,    8'h00, 32'h0,         1, OUT_OK,   5'd1));
      directed_rows.push_back(row(CMD_ADD,    8'hFF, 32'hFFFF_FFFF, 1, OUT_OK,   5'd2));
      directed_rows.push_back(row(CMD_VERIFY, 8'h00, 32'hFFFF_FFFF, 0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_VERIFY, 8'hFF, 32'h0,         0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_ADD,    8'h5A, ADMIN_RESET,   0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_VERIFY, 8'h00, ADMIN_RESET,   1, OUT_OK,   5'd3));
      directed_rows.push_back(row(CMD_ADD,    8'h00, 32'h1234_5678, 0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_DELETE, 8'h00, 32'hA5A5_A5A5, 0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_VERIFY, 8'h00, 32'h0,         0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_VERIFY, 8'h00, 32'h1234_5678, 0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_DELETE, 8'hFF, 32'h0,         0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_DELETE, 8'h00, 32'h0,         0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_VERIFY, 8'h00, 32'h1234_5678, 0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_UNUSED, 8'h00, 32'h0,         0, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_DELETE, 8'h5A, 32'h0,         1, OUT_OK,   5'd0));
      directed_rows.push_back(row(CMD_VERIFY, 8'h00, 32'hFFFF_FFFF, 1, OUT_FAIL, 5'd0));
      directed_rows.push_back(row(CMD_DELETE, 8'h5A, 32'h0,         1, OUT_FAIL, 5'd0));

      repeat (9) @(negedge clock);
      reset = 1'b0;

      src_idle_pct = 13;
      rcv_stall_pct = 13;
      foreach (directed_rows[i]) send_cmd(directed_rows[i]);

      for (p = 0; p < 6; p++) begin
         drain_pending();
         case (p)
            0: begin
               src_idle_pct = 0;  rcv_stall_pct = 0;  add_pct = 60;
               write_admin(32'h0000_0000);
            end
            1: begin
               src_idle_pct = 75; rcv_stall_pct = 0;  add_pct = 30;
               write_admin(32'hFFFF_FFFF);
            end
            2: begin
               src_idle_pct = 0;  rcv_stall_pct = 75; add_pct = 45;
               write_admin($urandom);
            end
            3: begin
               src_idle_pct = 13; rcv_stall_pct = 13; add_pct = 60;
               write_admin(ADMIN_RESET);
            end
            4: begin
               src_idle_pct = 0;  rcv_stall_pct = 0;  add_pct = 30;
               write_admin($urandom);
            end
            default: begin
               src_idle_pct = 13; rcv_stall_pct = 13; add_pct = 45;
               write_admin($urandom);
            end
         endcase
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            pick_random_cmd(add_pct, r);
            if ($urandom_range(59) == 0) drain_pending();
            send_cmd(r);
         end
      end

      drain_pending();
      repeat (40) @(posedge clock);

      $display("Ran %0d commands, %0d responses: %0d added, %0d full, %0d deleted, %0d not found",
               n_cmds, n_rsp, n_added, n_full, n_deleted, n_missing);
      $display("Verify: %0d admin, %0d user, %0d invalid; %0d unused, %0d admin writes",
               n_admin, n_user, n_invalid, n_unused, n_csr);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/cte_pkg.sv
design/cte_match.sv
design/credential_table_engine.sv
tb/tb_top.sv
